[hw/rtl/rmsd_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rmsd_pkg
// Types and constants shared by the running mean and deviation block.
// ----------------------------------------------------------------------------
package rmsd_pkg;

	localparam int SAMPLE_W    = 16;
	localparam int SAMPLE_FRAC = 8;
	localparam int FRAC_W      = 16;
	localparam int COUNT_W     = 16;
	localparam int MEAN_W      = 24;
	localparam int SD_W        = 24;
	localparam int DELTA_W     = MEAN_W + 1;
	localparam int PROD_W      = 2 * DELTA_W;
	localparam int SUM_W       = 64;
	localparam int ROOT_W      = SUM_W / 2;
	localparam int REM_W       = ROOT_W;
	localparam int SUB_W       = ROOT_W + 2;
	localparam int ITER_W      = 6;
	localparam int SCALE_SHIFT = FRAC_W - SAMPLE_FRAC;

	localparam logic [ITER_W-1:0] MEAN_STEP_LAST = ITER_W'(DELTA_W - 1);
	localparam logic [ITER_W-1:0] VAR_STEP_LAST  = ITER_W'(SUM_W - 1);
	localparam logic [ITER_W-1:0] ROOT_STEP_LAST = ITER_W'(ROOT_W - 1);

	typedef struct packed {
		logic signed [SAMPLE_W-1:0] sample;
		logic                       last_sample;
	} in_word_t;

	typedef struct packed {
		logic signed [MEAN_W-1:0] mean_out;
		logic [SD_W-1:0]          stddev_out;
		logic [COUNT_W-1:0]       samples_seen;
		logic                     series_end;
	} out_word_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_DIV_MEAN,
		ST_UPDATE,
		ST_MULT,
		ST_ACCUM,
		ST_DIV_VAR,
		ST_SQRT,
		ST_FINISH
	} state_t;

endpackage

[hw/rtl/running_mean_stddev_top.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// running_mean_stddev_top
// Welford running mean and population standard deviation of a sample series.
// ----------------------------------------------------------------------------
// Each accepted word is one Q8.8 sample; the block answers with the running
// mean and the population standard deviation of the series so far, both in
// Q8.16, and a sample flagged as last closes the series and clears the state
// once its result is formed. One 34-bit subtractor does all the iterative
// work for a word, first 25 steps of the mean division, then 64 steps of the
// variance division and 32 steps of the square root, with further states for
// the mean update, the multiply, the accumulate, the hand-over to the output
// register and the return to idle. The input is stalled from acceptance until
// the return to idle, but a finished result may wait in the output register
// while the next sample is taken.
module running_mean_stddev_top
	import rmsd_pkg::*;
(
	input  logic      clk,
	input  logic      arst_n,
	input  logic      smp_valid,
	output logic      smp_stall,
	input  in_word_t  smp_word,
	output logic      res_valid,
	input  logic      res_stall,
	output out_word_t res_word
);

	state_t state_q, state_nx;

	logic [COUNT_W-1:0]       count_q;
	logic signed [MEAN_W-1:0] mean_q;
	logic [SUM_W-1:0]         sum_q;
	logic                     out_valid_q;
	logic [ITER_W-1:0]        iter_q;

	logic signed [MEAN_W-1:0] x_q;
	logic                     last_q;
	logic                     neg_q;
	logic [DELTA_W-1:0]       dmag_q;
	logic [PROD_W-1:0]        prod_q;
	logic [SUM_W-1:0]         dq_q;
	logic [REM_W-1:0]         rem_q;
	logic [ROOT_W-1:0]        root_q;
	out_word_t                out_q;

	logic                     smp_take;
	logic                     res_take;
	logic                     step_done;
	logic                     out_load;
	logic signed [MEAN_W-1:0] x_in;
	logic signed [DELTA_W-1:0] delta_in;
	logic [DELTA_W-1:0]       dmag_in;
	logic [COUNT_W-1:0]       count_inc;
	logic [DELTA_W-1:0]       quot;
	logic signed [DELTA_W-1:0] quot_signed;
	logic signed [DELTA_W-1:0] mean_new;
	logic signed [DELTA_W-1:0] delta2;
	logic [DELTA_W-1:0]       d2mag;
	logic [SUM_W:0]           sum_add;
	logic [SUM_W-1:0]         sum_sat;
	logic [SUB_W-1:0]         sub_a;
	logic [SUB_W-1:0]         sub_b;
	logic [SUB_W:0]           sub_diff;
	logic                     sub_ge;
	logic [SD_W-1:0]          sd_sat;

	assign smp_take = smp_valid && !smp_stall;
	assign res_take = out_valid_q && !res_stall;
	assign res_valid = out_valid_q;
	assign res_word = out_q;

	assign x_in = {smp_word.sample, SCALE_SHIFT'(0)};
	assign delta_in = DELTA_W'(x_in) - DELTA_W'(mean_q);
	assign dmag_in = delta_in[DELTA_W-1] ? DELTA_W'(-delta_in) : DELTA_W'(delta_in);
	assign count_inc = (count_q == '1) ? count_q : count_q + COUNT_W'(1);

	assign quot = dq_q[DELTA_W-1:0];
	assign quot_signed = neg_q ? -$signed(quot) : $signed(quot);
	assign mean_new = DELTA_W'(mean_q) + quot_signed;
	assign delta2 = DELTA_W'(x_q) - DELTA_W'(mean_q);
	assign d2mag = delta2[DELTA_W-1] ? DELTA_W'(-delta2) : DELTA_W'(delta2);

	assign sum_add = {1'b0, sum_q} + (SUM_W + 1)'(prod_q);
	assign sum_sat = sum_add[SUM_W] ? '1 : sum_add[SUM_W-1:0];

	assign sd_sat = (root_q[ROOT_W-1:SD_W] != '0) ? '1 : root_q[SD_W-1:0];

	// One subtractor serves both divisions and the square root.
	always_comb begin
		if (state_q == ST_SQRT) begin
			sub_a = {rem_q, dq_q[SUM_W-1 -: 2]};
			sub_b = {root_q, 2'b01};
		end else begin
			sub_a = SUB_W'({rem_q[COUNT_W-1:0], dq_q[SUM_W-1]});
			sub_b = SUB_W'(count_q);
		end
		sub_diff = {1'b0, sub_a} - {1'b0, sub_b};
		sub_ge = !sub_diff[SUB_W];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_nx;
		end
	end

	always_comb begin
		state_nx = state_q;
		smp_stall = 1'b1;
		step_done = 1'b0;
		out_load = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				smp_stall = 1'b0;
				if (smp_valid) begin
					state_nx = ST_DIV_MEAN;
				end
			end
			ST_DIV_MEAN: begin
				step_done = (iter_q == MEAN_STEP_LAST);
				if (step_done) begin
					state_nx = ST_UPDATE;
				end
			end
			ST_UPDATE: state_nx = ST_MULT;
			ST_MULT:   state_nx = ST_ACCUM;
			ST_ACCUM:  state_nx = ST_DIV_VAR;
			ST_DIV_VAR: begin
				step_done = (iter_q == VAR_STEP_LAST);
				if (step_done) begin
					state_nx = ST_SQRT;
				end
			end
			ST_SQRT: begin
				step_done = (iter_q == ROOT_STEP_LAST);
				if (step_done) begin
					state_nx = ST_FINISH;
				end
			end
			ST_FINISH: begin
				if (!out_valid_q || !res_stall) begin
					out_load = 1'b1;
					state_nx = ST_IDLE;
				end
			end
			default: state_nx = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
			mean_q <= '0;
			sum_q <= '0;
			out_valid_q <= 1'b0;
			iter_q <= '0;
		end else begin
			if (smp_take) begin
				count_q <= count_inc;
			end
			if (state_q == ST_UPDATE) begin
				mean_q <= mean_new[MEAN_W-1:0];
			end
			if (state_q == ST_ACCUM) begin
				sum_q <= sum_sat;
			end
			if (out_load && last_q) begin
				count_q <= '0;
				mean_q <= '0;
				sum_q <= '0;
			end
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (res_take) begin
				out_valid_q <= 1'b0;
			end
			if (state_q == ST_DIV_MEAN || state_q == ST_DIV_VAR || state_q == ST_SQRT) begin
				iter_q <= step_done ? '0 : iter_q + ITER_W'(1);
			end else begin
				iter_q <= '0;
			end
		end
	end

	always_ff @(posedge clk) begin
		unique case (state_q)
			ST_IDLE: begin
				x_q <= x_in;
				last_q <= smp_word.last_sample;
				neg_q <= delta_in[DELTA_W-1];
				dmag_q <= dmag_in;
				dq_q <= {dmag_in, (SUM_W - DELTA_W)'(0)};
				rem_q <= '0;
			end
			ST_DIV_MEAN, ST_DIV_VAR: begin
				dq_q <= {dq_q[SUM_W-2:0], sub_ge};
				if (step_done && state_q == ST_DIV_VAR) begin
					rem_q <= '0;
					root_q <= '0;
				end else begin
					rem_q <= REM_W'(sub_ge ? sub_diff[COUNT_W-1:0] : sub_a[COUNT_W-1:0]);
				end
			end
			ST_UPDATE: begin
			end
			ST_MULT: begin
				prod_q <= dmag_q * d2mag;
			end
			ST_ACCUM: begin
				dq_q <= sum_sat;
				rem_q <= '0;
			end
			ST_SQRT: begin
				dq_q <= {dq_q[SUM_W-3:0], 2'b00};
				rem_q <= sub_ge ? sub_diff[REM_W-1:0] : sub_a[REM_W-1:0];
				root_q <= {root_q[ROOT_W-2:0], sub_ge};
			end
			ST_FINISH: begin
				if (out_load) begin
					out_q.mean_out <= mean_q;
					out_q.stddev_out <= sd_sat;
					out_q.samples_seen <= count_q;
					out_q.series_end <= last_q;
				end
			end
			default: begin
			end
		endcase
	end

endmodule

[hw/rtl/rmsd_checker.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rmsd_checker
// Port-level checks on the running mean and deviation block.
// ----------------------------------------------------------------------------
module rmsd_checker
	import rmsd_pkg::*;
(
	input logic      clk,
	input logic      arst_n,
	input logic      smp_valid,
	input logic      smp_stall,
	input logic      res_valid,
	input logic      res_stall,
	input out_word_t res_word
);

	// A sample keeps the block busy for the cycle after it is taken.
	assert property (@(posedge clk) disable iff (!arst_n)
		(smp_valid && !smp_stall) |=> smp_stall)
		else $error("input taken twice in consecutive cycles");

	assert property (@(posedge clk) disable iff (!arst_n)
		(res_valid && res_stall) |=> res_valid)
		else $error("result word withdrawn while stalled");

	assert property (@(posedge clk) disable iff (!arst_n)
		(res_valid && res_stall) |=> $stable(res_word))
		else $error("result word changed while stalled");

	// A series of one sample has no spread.
	assert property (@(posedge clk) disable iff (!arst_n)
		(res_valid && res_word.samples_seen == COUNT_W'(1)) |-> (res_word.stddev_out == '0))
		else $error("deviation not zero for the first sample of a series");

	assert property (@(posedge clk) disable iff (!arst_n)
		res_valid |-> (res_word.samples_seen != '0))
		else $error("result word reports no samples");

endmodule

bind running_mean_stddev_top rmsd_checker u_rmsd_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.smp_valid (smp_valid),
	.smp_stall (smp_stall),
	.res_valid (res_valid),
	.res_stall (res_stall),
	.res_word  (res_word)
);

[test/running_mean_stddev_top_tb.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// running_mean_stddev_top_tb
// Self-checking bench for the running mean and standard deviation block.
// ----------------------------------------------------------------------------
// Sample words are sent through the valid/stall input and every accepted word
// is run through a bit-exact Welford model held in the bench, whose answer is
// queued. A separate process takes each result word off the output and
// compares it field by field with the oldest queued answer. The run covers
// directed extremes, random series of mixed length, a long output hold that
// backs the block up, a pause in the middle of a series and back-to-back
// traffic with no idling.
// ----------------------------------------------------------------------------
module running_mean_stddev_top_tb
	import rmsd_pkg::*;
();

	localparam int     HOLD_CYCLES    = 600;
	localparam int     WATCHDOG_LIMIT = 4000;
	localparam int     TAIL_CYCLES    = 300;
	localparam int     RANDOM_SAMPLES = 380;
	localparam longint MEAN_HI        = (longint'(1) <<< (MEAN_W - 1)) - 1;
	localparam longint MEAN_LO        = -(longint'(1) <<< (MEAN_W - 1));
	localparam logic [63:0] SD_HI     = (64'd1 << SD_W) - 1;

	logic      clk;
	logic      arst_n    = 1'b0;
	logic      smp_valid = 1'b0;
	logic      smp_stall;
	in_word_t  smp_word  = '0;
	logic      res_valid;
	logic      res_stall = 1'b0;
	out_word_t res_word;

	logic [COUNT_W-1:0] series_count  = '0;
	longint             series_mean   = 0;
	logic [63:0]        series_sq_sum = '0;

	out_word_t expected_stats[$];
	bit        idle_en       = 1'b1;
	bit        hold_request  = 1'b0;
	int        samples_sent  = 0;
	int        series_closed = 0;
	int        results_seen  = 0;
	int        error_count   = 0;
	int        holds_done    = 0;
	int        quiet_cycles  = 0;

	running_mean_stddev_top dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.smp_valid (smp_valid),
		.smp_stall (smp_stall),
		.smp_word  (smp_word),
		.res_valid (res_valid),
		.res_stall (res_stall),
		.res_word  (res_word)
	);

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	function automatic logic [63:0] floor_sqrt(input logic [63:0] v);
		logic [63:0] root;
		logic [63:0] rem;
		logic [63:0] probe;
		root  = '0;
		rem   = v;
		probe = 64'h4000_0000_0000_0000;
		while (probe > rem)
			probe = probe >> 2;
		while (probe != 0) begin
			if (rem >= root + probe) begin
				rem  = rem - (root + probe);
				root = (root >> 1) + probe;
			end else begin
				root = root >> 1;
			end
			probe = probe >> 2;
		end
		return root;
	endfunction

	function automatic out_word_t welford_predict(input in_word_t w);
		longint       x;
		longint       delta;
		longint       delta2;
		longint       m;
		logic [63:0]  mag_a;
		logic [63:0]  mag_b;
		logic [63:0]  prod;
		logic [63:0]  var_q;
		logic [63:0]  root;
		logic [127:0] prod_wide;
		logic [64:0]  sum_wide;
		out_word_t    r;
		x = longint'(w.sample) * (longint'(1) <<< SCALE_SHIFT);
		if (series_count != '1)
			series_count = series_count + COUNT_W'(1);
		delta       = x - series_mean;
		series_mean = series_mean + delta / longint'(series_count);
		delta2      = x - series_mean;
		mag_a       = (delta < 0) ? 64'(-delta) : 64'(delta);
		mag_b       = (delta2 < 0) ? 64'(-delta2) : 64'(delta2);
		prod_wide   = {64'd0, mag_a} * {64'd0, mag_b};
		prod        = (prod_wide[127:64] != 0) ? '1 : prod_wide[63:0];
		sum_wide    = {1'b0, series_sq_sum} + {1'b0, prod};
		series_sq_sum = sum_wide[64] ? '1 : sum_wide[63:0];
		var_q = series_sq_sum / 64'(series_count);
		root  = floor_sqrt(var_q);
		if (root > SD_HI)
			root = SD_HI;
		m = series_mean;
		if (m > MEAN_HI)
			m = MEAN_HI;
		if (m < MEAN_LO)
			m = MEAN_LO;
		r.mean_out     = m[MEAN_W-1:0];
		r.stddev_out   = root[SD_W-1:0];
		r.samples_seen = series_count;
		r.series_end   = w.last_sample;
		if (w.last_sample) begin
			series_count  = '0;
			series_mean   = 0;
			series_sq_sum = '0;
		end
		return r;
	endfunction

	function automatic logic signed [SAMPLE_W-1:0] pick_sample(input int centre);
		case ($urandom_range(0, 9))
			0: return ($urandom_range(0, 1) != 0) ? 16'sh7FFF : 16'sh8000;
			1, 2, 3: return SAMPLE_W'($urandom);
			default: return SAMPLE_W'(centre + int'($urandom_range(0, 512)) - 256);
		endcase
	endfunction

	task automatic send_sample(input logic signed [SAMPLE_W-1:0] value, input logic last_flag);
		int       gap;
		in_word_t w;
		w.sample      = value;
		w.last_sample = last_flag;
		gap = idle_en ? $urandom_range(0, 6) : 0;
		if (gap > 0) begin
			smp_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		smp_valid <= 1'b1;
		smp_word  <= w;
		do @(posedge clk); while (smp_stall);
		expected_stats.push_back(welford_predict(w));
		samples_sent++;
		if (last_flag)
			series_closed++;
	endtask

	task automatic drain_results();
		smp_valid <= 1'b0;
		do @(posedge clk); while (expected_stats.size() != 0);
	endtask

	task automatic check_result(input out_word_t got);
		out_word_t want;
		bit        bad;
		results_seen++;
		if (expected_stats.size() == 0) begin
			error_count++;
			if (error_count <= 10)
				$display("Unexpected result word: mean %0d sd %0d count %0d end %0b",
					$signed(got.mean_out), got.stddev_out, got.samples_seen, got.series_end);
		end else begin
			want = expected_stats.pop_front();
			bad  = 1'b0;
			if (got.mean_out !== want.mean_out)
				bad = 1'b1;
			if (got.stddev_out !== want.stddev_out)
				bad = 1'b1;
			if (got.samples_seen !== want.samples_seen)
				bad = 1'b1;
			if (got.series_end !== want.series_end)
				bad = 1'b1;
			if (bad) begin
				error_count++;
				if (error_count <= 10) begin
					$display("Result %0d expected/actual: mean %0d/%0d sd %0d/%0d",
						results_seen, $signed(want.mean_out), $signed(got.mean_out),
						want.stddev_out, got.stddev_out);
					$display("Result %0d expected/actual: count %0d/%0d end %0b/%0b",
						results_seen, want.samples_seen, got.samples_seen,
						want.series_end, got.series_end);
				end
			end
		end
	endtask

	initial begin : result_sink
		int wait_cycles;
		@(posedge arst_n);
		forever begin
			wait_cycles = idle_en ? $urandom_range(0, 6) : 0;
			if (hold_request) begin
				wait_cycles  = HOLD_CYCLES;
				hold_request = 1'b0;
				holds_done++;
			end
			if (wait_cycles > 0) begin
				res_stall <= 1'b1;
				do @(posedge clk); while (!res_valid);
				repeat (wait_cycles - 1) @(posedge clk);
				res_stall <= 1'b0;
			end
			do @(posedge clk); while (!res_valid);
			check_result(res_word);
		end
	end

	always @(posedge clk) begin
		if (!arst_n || (smp_valid && !smp_stall) || (res_valid && !res_stall)) begin
			quiet_cycles <= 0;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
			if (quiet_cycles >= WATCHDOG_LIMIT) begin
				$display("Verification failed");
				$finish;
			end
		end
	end

	task automatic test_directed_extremes();
		int dir_samples [21];
		bit dir_last [21];
		dir_samples = '{32767, -32768, 0, -32768, 32767, -32768, 32767, 1, -1, 0, 2, -3,
			100, 100, 100, 100, -1, -1, -2, 32767, -32768};
		dir_last = '{1, 1, 1, 0, 0, 0, 1, 0, 0, 0, 0, 1, 0, 0, 0, 1, 0, 0, 1, 0, 1};
		for (int i = 0; i < 21; i++)
			send_sample(SAMPLE_W'(dir_samples[i]), dir_last[i]);
	endtask

	task automatic test_random_series(input int target, input bit pause_mid_series);
		int start;
		int len;
		int centre;
		bit paused;
		start  = samples_sent;
		paused = 1'b0;
		while (samples_sent - start < target) begin
			len = ($urandom_range(0, 7) == 0) ? $urandom_range(20, 60) : $urandom_range(1, 10);
			centre = int'($urandom_range(0, 65535)) - 32768;
			for (int i = 0; i < len; i++) begin
				if (pause_mid_series && !paused && i > 0 && samples_sent - start > target / 2) begin
					drain_results();
					paused = 1'b1;
				end
				send_sample(pick_sample(centre), i == len - 1);
			end
		end
	endtask

	task automatic test_output_hold();
		idle_en      = 1'b1;
		hold_request = 1'b1;
		test_random_series(40, 1'b0);
	endtask

	task automatic test_back_to_back();
		idle_en = 1'b0;
		test_random_series(60, 1'b0);
		idle_en = 1'b1;
	endtask

	initial begin
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_directed_extremes();
		drain_results();
		test_random_series(RANDOM_SAMPLES, 1'b1);
		drain_results();
		test_output_hold();
		drain_results();
		test_back_to_back();
		drain_results();
		repeat (TAIL_CYCLES) @(posedge clk);
		if (expected_stats.size() != 0)
			error_count += expected_stats.size();
		$display("Run summary: %0d samples in %0d closed series, %0d results compared, %0d errors.",
			samples_sent, series_closed, results_seen, error_count);
		$display("Covered extreme and random series, %0d long output hold(s), %s",
			holds_done, "a mid-series pause and traffic with no idling.");
		if (error_count == 0) begin
			$display("Verification passed");
		end else begin
			$display("Verification failed");
		end
		$finish;
	end

endmodule
